[rtl/ufd_pkg.sv]
// shared types and constants for the uart frame deframer
// no dependencies

package ufd_pkg;

   localparam int BYTE_W = 8;
   localparam int HALF_W = 16;
   localparam int EVENT_W = 2;
   localparam int PHASE_W = 3;
   localparam int CSR_INDEX_W = 2;

   // configuration register indexes
   localparam logic [CSR_INDEX_W-1:0] CSR_MAGIC_FIRST  = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_MAGIC_SECOND = 2'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_MAGIC_THIRD  = 2'd2;
   localparam logic [CSR_INDEX_W-1:0] CSR_TAIL_VALUE   = 2'd3;

   localparam logic [BYTE_W-1:0] MAGIC_FIRST_RST  = 8'hA5;
   localparam logic [BYTE_W-1:0] MAGIC_SECOND_RST = 8'h5A;
   localparam logic [BYTE_W-1:0] MAGIC_THIRD_RST  = 8'h23;
   localparam logic [BYTE_W-1:0] TAIL_VALUE_RST   = 8'hAA;

   // parser phases
   localparam logic [PHASE_W-1:0] PH_IDLE    = 3'd0;
   localparam logic [PHASE_W-1:0] PH_HEAD    = 3'd1;
   localparam logic [PHASE_W-1:0] PH_LEN     = 3'd2;
   localparam logic [PHASE_W-1:0] PH_IDENT   = 3'd3;
   localparam logic [PHASE_W-1:0] PH_RESV    = 3'd4;
   localparam logic [PHASE_W-1:0] PH_PAYLOAD = 3'd5;
   localparam logic [PHASE_W-1:0] PH_TAIL    = 3'd6;

   // result events
   localparam logic [EVENT_W-1:0] EV_NONE     = 2'd0;
   localparam logic [EVENT_W-1:0] EV_PAYLOAD  = 2'd1;
   localparam logic [EVENT_W-1:0] EV_COMPLETE = 2'd2;
   localparam logic [EVENT_W-1:0] EV_ERROR    = 2'd3;

   typedef struct packed {
      logic [BYTE_W-1:0] magic_first;
      logic [BYTE_W-1:0] magic_second;
      logic [BYTE_W-1:0] magic_third;
      logic [BYTE_W-1:0] tail_value;
   } cfg_type;

   typedef struct packed {
      logic [EVENT_W-1:0] event_res;
      logic [BYTE_W-1:0]  payload_byte;
      logic [HALF_W-1:0]  payload_index;
      logic [HALF_W-1:0]  frame_length;
      logic [HALF_W-1:0]  frame_ident;
      logic [BYTE_W-1:0]  reserve_byte;
   } result_type;

endpackage

[rtl/ufd_csr.sv]
// configuration registers for the uart frame deframer
// depends on ufd_pkg

module ufd_csr (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           wr_en,
   input  logic [ufd_pkg::CSR_INDEX_W-1:0] wr_index,
   input  logic [ufd_pkg::BYTE_W-1:0]      wr_data,
   output ufd_pkg::cfg_type               cfg
);
   import ufd_pkg::*;

   cfg_type cfg_ff;
   cfg_type cfg_in;

   always_comb begin
      cfg_in = cfg_ff;
      if (wr_en) begin
         case (wr_index)
            CSR_MAGIC_FIRST:  cfg_in.magic_first  = wr_data;
            CSR_MAGIC_SECOND: cfg_in.magic_second = wr_data;
            CSR_MAGIC_THIRD:  cfg_in.magic_third  = wr_data;
            CSR_TAIL_VALUE:   cfg_in.tail_value   = wr_data;
            default:          cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.magic_first  <= MAGIC_FIRST_RST;
         cfg_ff.magic_second <= MAGIC_SECOND_RST;
         cfg_ff.magic_third  <= MAGIC_THIRD_RST;
         cfg_ff.tail_value   <= TAIL_VALUE_RST;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

[rtl/ufd_parse.sv]
// frame parser state and per-word result logic
// depends on ufd_pkg

module ufd_parse (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      accept,
   input  logic [ufd_pkg::BYTE_W-1:0] rx_byte,
   input  ufd_pkg::cfg_type          cfg,
   output ufd_pkg::result_type       res
);
   import ufd_pkg::*;

   logic [PHASE_W-1:0] phase_ff, phase_in;
   logic [HALF_W-1:0]  count_ff, count_in;
   logic [HALF_W-1:0]  length_ff, length_in;
   logic [HALF_W-1:0]  ident_ff, ident_in;
   logic [BYTE_W-1:0]  reserve_ff, reserve_in;
   logic [EVENT_W-1:0] ev;
   logic [BYTE_W-1:0]  pbyte;
   logic [HALF_W-1:0]  pindex;
   logic               err;

   always_comb begin
      phase_in   = phase_ff;
      count_in   = count_ff;
      length_in  = length_ff;
      ident_in   = ident_ff;
      reserve_in = reserve_ff;
      ev         = EV_NONE;
      pbyte      = '0;
      pindex     = '0;
      err        = 1'b0;

      case (phase_ff)
         PH_IDLE: begin
            if (rx_byte == cfg.magic_first) begin
               phase_in = PH_HEAD;
               count_in = 16'd1;
            end
         end
         PH_HEAD: begin
            if (count_ff == 16'd1 && rx_byte == cfg.magic_second) begin
               count_in = 16'd2;
            end else if (count_ff == 16'd2 && rx_byte == cfg.magic_third) begin
               phase_in = PH_LEN;
               count_in = '0;
            end else begin
               err = 1'b1;
            end
         end
         PH_LEN: begin
            if (count_ff == 16'd0) begin
               length_in = {8'd0, rx_byte};
               count_in  = 16'd1;
            end else if (count_ff == 16'd1) begin
               length_in = {rx_byte, length_ff[7:0]};
               count_in  = '0;
               phase_in  = PH_IDENT;
            end else begin
               err = 1'b1;
            end
         end
         PH_IDENT: begin
            if (count_ff == 16'd0) begin
               ident_in = {8'd0, rx_byte};
               count_in = 16'd1;
            end else if (count_ff == 16'd1) begin
               ident_in = {ident_ff[7:0], rx_byte};
               count_in = '0;
               phase_in = PH_RESV;
            end else begin
               err = 1'b1;
            end
         end
         PH_RESV: begin
            if (count_ff == 16'd0) begin
               reserve_in = rx_byte;
               count_in   = 16'd1;
            end else if (count_ff == 16'd1) begin
               count_in = '0;
               phase_in = PH_PAYLOAD;
            end else begin
               err = 1'b1;
            end
         end
         PH_PAYLOAD: begin
            if (count_ff < length_ff) begin
               ev       = EV_PAYLOAD;
               pbyte    = rx_byte;
               pindex   = count_ff;
               count_in = count_ff + 16'd1;
            end else begin
               // checksum byte skipped
               phase_in = PH_TAIL;
               count_in = '0;
            end
         end
         PH_TAIL: begin
            if (rx_byte == cfg.tail_value) begin
               ev       = EV_COMPLETE;
               phase_in = PH_IDLE;
               count_in = '0;
            end else begin
               err = 1'b1;
            end
         end
         default: begin
            phase_in = PH_IDLE;
            count_in = '0;
         end
      endcase

      if (err) begin
         phase_in = PH_IDLE;
         count_in = '0;
         res      = '0;
         res.event_res = EV_ERROR;
      end else begin
         res.event_res     = ev;
         res.payload_byte  = pbyte;
         res.payload_index = pindex;
         res.frame_length  = length_in;
         res.frame_ident   = ident_in;
         res.reserve_byte  = reserve_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff   <= PH_IDLE;
         count_ff   <= '0;
         length_ff  <= '0;
         ident_ff   <= '0;
         reserve_ff <= '0;
      end else if (accept) begin
         phase_ff   <= phase_in;
         count_ff   <= count_in;
         length_ff  <= length_in;
         ident_ff   <= ident_in;
         reserve_ff <= reserve_in;
      end
   end

endmodule

[rtl/ufd_out.sv]
// result register with skid stage for the uart frame deframer
// depends on ufd_pkg

module ufd_out (
   input  logic                clock,
   input  logic                reset,
   input  logic                in_valid,
   input  ufd_pkg::result_type in_data,
   input  logic                out_stall,
   output logic                out_valid,
   output ufd_pkg::result_type out_data,
   output logic                skid_full
);
   import ufd_pkg::*;

   logic       main_valid_ff, main_valid_in;
   logic       skid_valid_ff, skid_valid_in;
   result_type main_data_ff, main_data_in;
   result_type skid_data_ff, skid_data_in;
   logic       main_free;

   always_comb begin
      main_free     = !main_valid_ff || !out_stall;
      main_valid_in = main_valid_ff;
      main_data_in  = main_data_ff;
      skid_valid_in = skid_valid_ff;
      skid_data_in  = skid_data_ff;
      if (main_free) begin
         if (skid_valid_ff) begin
            main_valid_in = 1'b1;
            main_data_in  = skid_data_ff;
            skid_valid_in = 1'b0;
         end else begin
            main_valid_in = in_valid;
            main_data_in  = in_data;
         end
      end else if (in_valid) begin
         skid_valid_in = 1'b1;
         skid_data_in  = in_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         main_valid_ff <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         main_valid_ff <= main_valid_in;
         skid_valid_ff <= skid_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      main_data_ff <= main_data_in;
      skid_data_ff <= skid_data_in;
   end

   assign out_valid = main_valid_ff;
   assign out_data  = main_data_ff;
   assign skid_full = skid_valid_ff;

endmodule

[rtl/uart_frame_deframer.sv]
// uart frame deframer top level: config registers, parser and result register
// a result goes into the result register, or into the skid register while rsp_stall holds the result register
// throughput: one word per cycle while req_stall is low, as the parser updates once per accepted word
// req_stall rises only when the result and skid registers are both full
// reset (synchronous): parser idle, header registers zero, config to defaults
// depends on ufd_pkg, ufd_csr, ufd_parse, ufd_out

module uart_frame_deframer (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_valid,
   output logic                            req_stall,
   input  logic [ufd_pkg::BYTE_W-1:0]       req_rx_byte,
   output logic                            rsp_valid,
   input  logic                            rsp_stall,
   output logic [ufd_pkg::EVENT_W-1:0]      rsp_event_res,
   output logic [ufd_pkg::BYTE_W-1:0]       rsp_payload_byte,
   output logic [ufd_pkg::HALF_W-1:0]       rsp_payload_index,
   output logic [ufd_pkg::HALF_W-1:0]       rsp_frame_length,
   output logic [ufd_pkg::HALF_W-1:0]       rsp_frame_ident,
   output logic [ufd_pkg::BYTE_W-1:0]       rsp_reserve_byte,
   input  logic                            csr_valid,
   output logic                            csr_ready,
   input  logic [ufd_pkg::CSR_INDEX_W-1:0]  csr_index,
   input  logic [ufd_pkg::BYTE_W-1:0]       csr_data
);
   import ufd_pkg::*;

   cfg_type    cfg;
   result_type res;
   result_type out_data;
   logic       accept;
   logic       skid_full;

   assign csr_ready = 1'b1;
   assign req_stall = skid_full;
   assign accept    = req_valid && !skid_full;

   ufd_csr u_csr (
      .clock    (clock),
      .reset    (reset),
      .wr_en    (csr_valid && csr_ready),
      .wr_index (csr_index),
      .wr_data  (csr_data),
      .cfg      (cfg)
   );

   ufd_parse u_parse (
      .clock   (clock),
      .reset   (reset),
      .accept  (accept),
      .rx_byte (req_rx_byte),
      .cfg     (cfg),
      .res     (res)
   );

   ufd_out u_out (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (accept),
      .in_data   (res),
      .out_stall (rsp_stall),
      .out_valid (rsp_valid),
      .out_data  (out_data),
      .skid_full (skid_full)
   );

   assign rsp_event_res     = out_data.event_res;
   assign rsp_payload_byte  = out_data.payload_byte;
   assign rsp_payload_index = out_data.payload_index;
   assign rsp_frame_length  = out_data.frame_length;
   assign rsp_frame_ident   = out_data.frame_ident;
   assign rsp_reserve_byte  = out_data.reserve_byte;

endmodule
